### hw/rtl/cdt_pkg.sv
package cdt_pkg;

   // Counter reload value and its decimal digits
   localparam int unsigned COUNT_START = 999;
   localparam logic [9:0] COUNT_START_VAL = 10'(COUNT_START);
   localparam logic [3:0] START_HUNDREDS = 4'(COUNT_START / 100);
   localparam logic [3:0] START_TENS = 4'((COUNT_START / 10) % 10);
   localparam logic [3:0] START_UNITS = 4'(COUNT_START % 10);

   localparam logic [15:0] GUARD_MAX = 16'hFFFF;

   // Register indexes
   localparam logic CSR_COUNT_PERIOD = 1'b0;
   localparam logic CSR_DEBOUNCE = 1'b1;

   localparam logic [15:0] COUNT_PERIOD_RST = 16'd100;
   localparam logic [15:0] DEBOUNCE_RST = 16'd200;

   // Digit positions
   localparam logic [1:0] POS_UNITS = 2'd1;
   localparam logic [1:0] POS_TENS = 2'd2;
   localparam logic [1:0] POS_HUNDREDS = 2'd3;

   // Active-low digit enables
   localparam logic [2:0] SEL_UNITS = 3'd6;
   localparam logic [2:0] SEL_TENS = 3'd5;
   localparam logic [2:0] SEL_HUNDREDS = 3'd3;

   localparam logic [7:0] DP_MASK = 8'h80;

   typedef struct packed {
      logic [3:0] hundreds;
      logic [3:0] tens;
      logic [3:0] units;
      logic [1:0] pos;
   } disp_type;

   function automatic logic [1:0] pos_norm(input logic [1:0] pos);
      pos_norm = (pos == 2'd0) ? POS_UNITS : pos;
   endfunction

   // Active-low glyphs, segments a..g in bits 0..6
   function automatic logic [7:0] glyph(input logic [3:0] digit);
      case (digit)
         4'd0: glyph = 8'h40;
         4'd1: glyph = 8'h79;
         4'd2: glyph = 8'h24;
         4'd3: glyph = 8'h30;
         4'd4: glyph = 8'h19;
         4'd5: glyph = 8'h12;
         4'd6: glyph = 8'h03;
         4'd7: glyph = 8'h78;
         4'd8: glyph = 8'h00;
         4'd9: glyph = 8'h10;
         default: glyph = 8'hFF;
      endcase
   endfunction

endpackage

### hw/rtl/cdt_if.sv
interface cdt_req_if;
   logic valid;
   logic ready;
   logic start_press;
   logic reset_press;

   modport source (output valid, output start_press, output reset_press, input ready);
   modport sink (input valid, input start_press, input reset_press, output ready);
endinterface

interface cdt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] segments;
   logic [2:0] digit_select;
   logic [9:0] count_now;
   logic       is_running;

   modport source (output valid, output segments, output digit_select, output count_now,
                   output is_running, input ready);
   modport sink (input valid, input segments, input digit_select, input count_now,
                 input is_running, output ready);
endinterface

### hw/rtl/countdown_timer_seven_segment_mux.sv
// Multiplexed seven-segment countdown timer.
// req_chan: one transaction per millisecond tick, carrying the start and
//   reset button rising-edge flags for that millisecond.
// rsp_chan: exactly one transaction per request: active-low segments
//   (bit 7 = decimal point), active-low digit select, the counter value and
//   the run flag after that tick.
// csr_*: write-only registers, index 0 = count period (ms), index 1 =
//   debounce window (ms). Write only while no transaction is in flight.
// The response is registered, valid in the cycle after the request
//   is accepted. Throughput: one transaction per cycle while rsp_chan.ready
//   holds no response back; the whole tick update is one pass of
//   combinational logic into the state and output registers.
// The counter is held both in binary (count_now) and as three decimal
//   digits, so the display needs no division.
// Reset: counter 999, stopped, units digit next, period and guard counters
//   cleared, registers back to 100 and 200, no response pending.
// Stall: a held response stays put; a new request is taken in the cycle the
//   held one leaves, so rsp_chan.ready reaches req_chan.ready directly.
module countdown_timer_seven_segment_mux (
   input  logic          clock,
   input  logic          reset,
   cdt_req_if.sink       req_chan,
   cdt_rsp_if.source     rsp_chan,
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [15:0]   csr_wdata
);

   // configuration
   logic [15:0] count_period_ff;
   logic [15:0] debounce_ff;

   // timer state
   logic [9:0]  count_ff, count_in;
   logic [3:0]  hund_ff, hund_in;
   logic [3:0]  tens_ff, tens_in;
   logic [3:0]  units_ff, units_in;
   logic        running_ff, running_in;
   logic [1:0]  pos_ff, pos_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [15:0] start_guard_ff, start_guard_in;
   logic [15:0] reset_guard_ff, reset_guard_in;

   // response register
   logic        rsp_valid_ff;
   logic [7:0]  segments_ff;
   logic [2:0]  digit_select_ff;
   logic [9:0]  count_now_ff;
   logic        is_running_ff;

   logic        accept;
   logic [15:0] start_adv, reset_adv, period, elapsed_inc;
   logic        start_ok, reset_ok, fire, running_a;
   logic [1:0]  pos_cur;
   cdt_pkg::disp_type disp;
   logic [7:0]  segments_in;
   logic [2:0]  digit_select_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      // debounce guards saturate
      start_adv = (start_guard_ff == cdt_pkg::GUARD_MAX) ? start_guard_ff
                                                         : start_guard_ff + 16'd1;
      reset_adv = (reset_guard_ff == cdt_pkg::GUARD_MAX) ? reset_guard_ff
                                                         : reset_guard_ff + 16'd1;
      start_ok = req_chan.start_press && (start_adv > debounce_ff);
      reset_ok = req_chan.reset_press && (reset_adv > debounce_ff);

      start_guard_in = start_ok ? 16'd0 : start_adv;
      reset_guard_in = reset_ok ? 16'd0 : reset_adv;

      // start toggles first, reset wins
      running_a  = start_ok ? !running_ff : running_ff;
      running_in = reset_ok ? 1'b0 : running_a;
      count_in = count_ff;
      hund_in  = hund_ff;
      tens_in  = tens_ff;
      units_in = units_ff;
      if (reset_ok) begin
         count_in = cdt_pkg::COUNT_START_VAL;
         hund_in  = cdt_pkg::START_HUNDREDS;
         tens_in  = cdt_pkg::START_TENS;
         units_in = cdt_pkg::START_UNITS;
      end

      // free-running period counter; zero period acts as one
      period = (count_period_ff == 16'd0) ? 16'd1 : count_period_ff;
      elapsed_inc = elapsed_ff + 16'd1;
      fire = (elapsed_inc >= period) || (elapsed_inc == 16'd0);
      elapsed_in = fire ? 16'd0 : elapsed_inc;

      if (fire && running_in) begin
         if (count_in == 10'd0) begin
            count_in = cdt_pkg::COUNT_START_VAL;
            hund_in  = cdt_pkg::START_HUNDREDS;
            tens_in  = cdt_pkg::START_TENS;
            units_in = cdt_pkg::START_UNITS;
         end else begin
            count_in = count_in - 10'd1;
            // decimal borrow chain
            if (units_in != 4'd0) begin
               units_in = units_in - 4'd1;
            end else begin
               units_in = 4'd9;
               if (tens_in != 4'd0) begin
                  tens_in = tens_in - 4'd1;
               end else begin
                  tens_in = 4'd9;
                  hund_in = hund_in - 4'd1;
               end
            end
         end
      end

      // digit scan
      pos_cur = cdt_pkg::pos_norm(pos_ff);
      pos_in  = (pos_cur == cdt_pkg::POS_HUNDREDS) ? cdt_pkg::POS_UNITS : pos_cur + 2'd1;

      disp.hundreds = hund_in;
      disp.tens     = tens_in;
      disp.units    = units_in;
      disp.pos      = pos_cur;
   end

   cdt_seg_enc u_seg_enc (
      .disp         (disp),
      .segments     (segments_in),
      .digit_select (digit_select_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_period_ff <= cdt_pkg::COUNT_PERIOD_RST;
         debounce_ff     <= cdt_pkg::DEBOUNCE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            cdt_pkg::CSR_COUNT_PERIOD: count_period_ff <= csr_wdata;
            cdt_pkg::CSR_DEBOUNCE:     debounce_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= cdt_pkg::COUNT_START_VAL;
         hund_ff        <= cdt_pkg::START_HUNDREDS;
         tens_ff        <= cdt_pkg::START_TENS;
         units_ff       <= cdt_pkg::START_UNITS;
         running_ff     <= 1'b0;
         pos_ff         <= cdt_pkg::POS_UNITS;
         elapsed_ff     <= 16'd0;
         start_guard_ff <= 16'd0;
         reset_guard_ff <= 16'd0;
      end else if (accept) begin
         count_ff       <= count_in;
         hund_ff        <= hund_in;
         tens_ff        <= tens_in;
         units_ff       <= units_in;
         running_ff     <= running_in;
         pos_ff         <= pos_in;
         elapsed_ff     <= elapsed_in;
         start_guard_ff <= start_guard_in;
         reset_guard_ff <= reset_guard_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         segments_ff     <= segments_in;
         digit_select_ff <= digit_select_in;
         count_now_ff    <= count_in;
         is_running_ff   <= running_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.segments     = segments_ff;
   assign rsp_chan.digit_select = digit_select_ff;
   assign rsp_chan.count_now    = count_now_ff;
   assign rsp_chan.is_running   = is_running_ff;

endmodule

### hw/rtl/cdt_seg_enc.sv
module cdt_seg_enc (
   input  cdt_pkg::disp_type disp,
   output logic [7:0]        segments,
   output logic [2:0]        digit_select
);

   logic [1:0] pos;
   logic [3:0] digit;

   always_comb begin
      pos = cdt_pkg::pos_norm(disp.pos);
      case (pos)
         cdt_pkg::POS_TENS: begin
            digit = disp.tens;
            digit_select = cdt_pkg::SEL_TENS;
         end
         cdt_pkg::POS_HUNDREDS: begin
            digit = disp.hundreds;
            digit_select = cdt_pkg::SEL_HUNDREDS;
         end
         default: begin
            digit = disp.units;
            digit_select = cdt_pkg::SEL_UNITS;
         end
      endcase
      // decimal point lit on tens only
      segments = cdt_pkg::glyph(digit)
               | ((pos == cdt_pkg::POS_TENS) ? 8'h00 : cdt_pkg::DP_MASK);
   end

endmodule

### hw/rtl/cdt_checker.sv
module cdt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] segments,
   input logic [2:0] digit_select,
   input logic [9:0] count_now
);

   // held response stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(segments)
         && $stable(digit_select) && $stable(count_now))
      else $error("stalled response changed");

   // response drained with nothing new taken leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("response repeated");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_now <= cdt_pkg::COUNT_START_VAL)
      else $error("counter out of range");

   // exactly one digit enabled, decimal point only on tens
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (digit_select == cdt_pkg::SEL_UNITS || digit_select == cdt_pkg::SEL_TENS
         || digit_select == cdt_pkg::SEL_HUNDREDS)
         && (segments[7] == (digit_select != cdt_pkg::SEL_TENS)))
      else $error("bad digit scan");

endmodule

bind countdown_timer_seven_segment_mux cdt_checker u_cdt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .segments     (rsp_chan.segments),
   .digit_select (rsp_chan.digit_select),
   .count_now    (rsp_chan.count_now)
);

### bench/countdown_timer_seven_segment_mux_tb.sv
module countdown_timer_seven_segment_mux_tb;

   // Active-low glyphs for digits 0..9, digit n at bits [8n +: 8]
   localparam logic [79:0] SEGMENT_FONT = {8'h10, 8'h00, 8'h78, 8'h03, 8'h12,
                                           8'h19, 8'h30, 8'h24, 8'h79, 8'h40};
   // Cycles the receiver refuses responses during a forced hold
   localparam int HOLD_CYCLES = 60;

   typedef struct packed {
      logic [7:0] segments;
      logic [2:0] digit_select;
      logic [9:0] count_now;
      logic       is_running;
   } frame_type;

   // Timer predictor plus the queue of display frames it has produced
   class display_scoreboard;
      logic [15:0] period_reg;
      logic [15:0] debounce_reg;
      logic [15:0] period_elapsed;
      logic [15:0] start_guard;
      logic [15:0] reset_guard;
      logic [9:0]  count;
      logic        running;
      logic [1:0]  digit_pos;
      frame_type   expected_frames[$];
      int          failures;

      function new();
         period_reg = cdt_pkg::COUNT_PERIOD_RST;
         debounce_reg = cdt_pkg::DEBOUNCE_RST;
         period_elapsed = '0;
         start_guard = '0;
         reset_guard = '0;
         count = cdt_pkg::COUNT_START_VAL;
         running = 1'b0;
         digit_pos = cdt_pkg::POS_UNITS;
         failures = 0;
      endfunction

      function void set_register(input logic index, input logic [15:0] value);
         if (index == cdt_pkg::CSR_COUNT_PERIOD) period_reg = value;
         else debounce_reg = value;
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction

      // One millisecond tick accepted by the block
      function void note_tick(input logic start_press, input logic reset_press);
         logic [15:0] period;
         logic [1:0]  pos;
         logic [9:0]  shown;
         logic [3:0]  digit;
         frame_type   f;
         start_guard = (start_guard == cdt_pkg::GUARD_MAX) ? cdt_pkg::GUARD_MAX
                                                            : start_guard + 16'd1;
         reset_guard = (reset_guard == cdt_pkg::GUARD_MAX) ? cdt_pkg::GUARD_MAX
                                                            : reset_guard + 16'd1;
         if (start_press && start_guard > debounce_reg) begin
            running = ~running;
            start_guard = '0;
         end
         // reset wins over a start in the same tick
         if (reset_press && reset_guard > debounce_reg) begin
            running = 1'b0;
            count = cdt_pkg::COUNT_START_VAL;
            reset_guard = '0;
         end
         period = (period_reg == 16'd0) ? 16'd1 : period_reg;
         period_elapsed = period_elapsed + 16'd1;
         if (period_elapsed >= period || period_elapsed == 16'd0) begin
            period_elapsed = '0;
            if (running) begin
               count = (count == 10'd0) ? cdt_pkg::COUNT_START_VAL : count - 10'd1;
            end
         end
         pos = (digit_pos == 2'd0) ? cdt_pkg::POS_UNITS : digit_pos;
         case (pos)
            cdt_pkg::POS_TENS: begin
               shown = count / 10;
               f.digit_select = cdt_pkg::SEL_TENS;
            end
            cdt_pkg::POS_HUNDREDS: begin
               shown = count / 100;
               f.digit_select = cdt_pkg::SEL_HUNDREDS;
            end
            default: begin
               shown = count;
               f.digit_select = cdt_pkg::SEL_UNITS;
            end
         endcase
         digit = 4'(shown % 10);
         f.segments = SEGMENT_FONT[digit * 8 +: 8];
         if (pos != cdt_pkg::POS_TENS) f.segments = f.segments | cdt_pkg::DP_MASK;
         f.count_now = count;
         f.is_running = running;
         digit_pos = (pos == cdt_pkg::POS_HUNDREDS) ? cdt_pkg::POS_UNITS : pos + 2'd1;
         expected_frames.push_back(f);
      endfunction

      function void compare_field(input string name, input int want, input int got);
         if (want != got) begin
            failures++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_frame(input frame_type got);
         frame_type want;
         if (expected_frames.size() == 0) begin
            failures++;
            $display("%0t unexpected response transaction: expected none, actual %h",
                     $time, got);
            return;
         end
         want = expected_frames.pop_front();
         compare_field("segments", want.segments, got.segments);
         compare_field("digit_select", want.digit_select, got.digit_select);
         compare_field("count_now", want.count_now, got.count_now);
         compare_field("is_running", want.is_running, got.is_running);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [15:0] csr_wdata;

   cdt_req_if req_chan();
   cdt_rsp_if rsp_chan();

   display_scoreboard board;

   // Idle switches; cleared together for the long run with no gaps
   bit sender_idles = 1'b1;
   bit sink_idles = 1'b1;
   // Bumped by the stimulus to ask the receiver for a long hold
   int stall_asks = 0;

   countdown_timer_seven_segment_mux dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: the slowest legal run is far below this
   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: random ready, plus a long hold on request. The hold is what
   // fills the response register and pushes back on the request side.
   initial begin : rsp_ready_driver
      int hold_left;
      int stall_served;
      hold_left = 0;
      stall_served = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_asks != stall_served) begin
            stall_served = stall_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !(sink_idles && $urandom_range(99) < 24);
         end
      end
   end

   // Every response transaction is checked against the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      frame_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.segments = rsp_chan.segments;
         got.digit_select = rsp_chan.digit_select;
         got.count_now = rsp_chan.count_now;
         got.is_running = rsp_chan.is_running;
         board.check_frame(got);
      end
   end

   // Offer one tick; returns once the transaction is taken, after any idle cycles.
   // valid stays high into the next call unless idle cycles are inserted.
   task automatic send_tick(input logic start_press, input logic reset_press);
      req_chan.valid <= 1'b1;
      req_chan.start_press <= start_press;
      req_chan.reset_press <= reset_press;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_tick(start_press, reset_press);
      while (sender_idles && $urandom_range(99) < 24) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Random ticks; reset presses come at a third of the start press rate
   task automatic run_ticks(input int n, input int press_pct);
      repeat (n) send_tick($urandom_range(99) < press_pct,
                           $urandom_range(99) < press_pct / 3);
   endtask

   // Stop offering and let every outstanding response come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_register(index, value);
   endtask

   initial begin : stimulus
      int period_v;
      int debounce_v;
      int pct;
      board = new();
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.start_press <= 1'b0;
      req_chan.reset_press <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= cdt_pkg::CSR_COUNT_PERIOD;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Out of reset: guards start from 0, so every press is inside the 200 ms window
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b1);
      drain();

      // Zero period behaves as 1 ms; zero debounce takes back-to-back presses
      write_reg(cdt_pkg::CSR_COUNT_PERIOD, 16'd0);
      write_reg(cdt_pkg::CSR_DEBOUNCE, 16'd0);
      send_tick(1'b1, 1'b0);
      repeat (3) send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);   // toggle then reload: stopped at the start value
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);   // reset while running
      drain();

      // Debounce edge: guard must exceed the window, equal is rejected
      write_reg(cdt_pkg::CSR_COUNT_PERIOD, 16'd2);
      write_reg(cdt_pkg::CSR_DEBOUNCE, 16'd2);
      repeat (4) send_tick(1'b1, 1'b0);
      drain();

      // Random phases over a spread of register settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               period_v = 1;
               debounce_v = 0;
               pct = 10;
            end
            1: begin
               period_v = 3;
               debounce_v = 2;
               pct = 40;
            end
            2: begin
               period_v = cdt_pkg::COUNT_PERIOD_RST;
               debounce_v = cdt_pkg::DEBOUNCE_RST;
               pct = 30;
            end
            3: begin
               period_v = $urandom_range(1, 12);
               debounce_v = $urandom_range(0, 25);
               pct = 15;
            end
            4: begin
               period_v = $urandom_range(1, 65535);
               debounce_v = $urandom_range(0, 65535);
               pct = 20;
            end
            default: begin
               period_v = $urandom_range(1, 8);
               debounce_v = $urandom_range(0, 10);
               pct = 25;
            end
         endcase
         write_reg(cdt_pkg::CSR_COUNT_PERIOD, 16'(period_v));
         write_reg(cdt_pkg::CSR_DEBOUNCE, 16'(debounce_v));
         // long receiver hold while ticks keep coming
         if (phase == 2) stall_asks++;
         // last phase runs with no idling on either side
         if (phase == 5) begin
            sender_idles = 1'b0;
            sink_idles = 1'b0;
         end
         run_ticks(120, pct);
         drain();
         sender_idles = 1'b1;
         sink_idles = 1'b1;
      end

      // Period dropped below the elapsed count fires on the next tick:
      // start running, let the period counter climb, then lower the period
      write_reg(cdt_pkg::CSR_COUNT_PERIOD, 16'hFFFF);
      write_reg(cdt_pkg::CSR_DEBOUNCE, 16'd0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      drain();
      write_reg(cdt_pkg::CSR_DEBOUNCE, 16'hFFFE);
      repeat (10) send_tick(1'b0, 1'b0);
      drain();
      write_reg(cdt_pkg::CSR_COUNT_PERIOD, 16'd3);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      drain();

      // Closing random mix
      write_reg(cdt_pkg::CSR_COUNT_PERIOD, 16'($urandom_range(1, 6)));
      write_reg(cdt_pkg::CSR_DEBOUNCE, 16'($urandom_range(0, 6)));
      run_ticks(60, 30);
      drain();

      repeat (4) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
